@@ rtl/core/rcw_pkg.sv @@
// ----------------------------------------------------------------------------
// rcw_pkg
// shared widths, constants and types of the raised cosine window block
// ----------------------------------------------------------------------------
package rcw_pkg;

	// field and register widths
	localparam int IDX_W      = 10;
	localparam int SIZE_W     = 11;
	localparam int ALPHA_W    = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_ADDR_W = 2;
	localparam int IN_TDATA_W = ((2 * IDX_W + 7) / 8) * 8;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 16'h8000;

	// pi in q2.30
	localparam int             PI_W  = 32;
	localparam logic [PI_W-1:0] PI_Q30 = 32'd3373259427;

	// angle divider: dividend pi*m + n, divisor 2n, quotient theta
	localparam int DVD_W         = PI_W + SIZE_W;
	localparam int DIV_QBITS     = 31;
	localparam int DIV_REM_W     = DVD_W - DIV_QBITS;
	localparam int DIV_PER_STAGE = 4;
	localparam int DIV_STAGES    = (DIV_QBITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

	// horner series of the quarter-wave cosine
	localparam int T2_W = 32;
	localparam int R_W  = 31;
	localparam int Y_W  = 33;
	localparam int Q0_W = 33;
	localparam int HORNER_TERMS = 6;
	localparam int HORNER_DIV [HORNER_TERMS] = '{132, 90, 56, 30, 12, 2};
	localparam logic [R_W-1:0] Q30_ONE = 31'h4000_0000;

	// axis factor in signed q30
	localparam int FACTOR_W = 32;
	localparam int PRD_W    = ALPHA_W + 1 + FACTOR_W;

	// quadrant, then stages for pi*m, divider, square, horner, product, factor
	localparam int AXIS_LAT = 5 + DIV_STAGES + 3 * HORNER_TERMS;

	typedef struct packed {
		logic [1:0] quad;
		logic       zero;
		logic       full;
	} cos_tag_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_WIDTH_SIZE  = 2'd0,
		REG_HEIGHT_SIZE = 2'd1,
		REG_ALPHA       = 2'd2
	} cfg_reg_t;

endpackage

@@ rtl/core/rcw_axis.sv @@
// ----------------------------------------------------------------------------
// rcw_axis
// pipelined axis factor alpha + (alpha - 1) * cos(2*pi*index/size) in q30
// ----------------------------------------------------------------------------
module rcw_axis (
	input  logic                                clk,
	input  logic                                adv,
	input  logic [rcw_pkg::IDX_W-1:0]           index,
	input  logic [rcw_pkg::SIZE_W-1:0]          size,
	input  logic [rcw_pkg::ALPHA_W-1:0]         alpha,
	output logic signed [rcw_pkg::FACTOR_W-1:0] factor
);
	import rcw_pkg::*;

	localparam int W13 = SIZE_W + 2;

	// quadrant split
	logic [W13-1:0]    i4, n1, n2, n3, base, rq;
	logic              ge1, ge2, ge3;
	logic [1:0]        quad;
	logic [SIZE_W-1:0] m_nx;
	cos_tag_t          tag_nx;

	logic [SIZE_W-1:0] m_s1;
	cos_tag_t          tag_s1;
	logic [DVD_W-1:0]  dvd_s2;
	cos_tag_t          tag_s2;

	always_comb begin
		i4   = {1'b0, index, 2'b00};
		n1   = W13'(size);
		n2   = W13'({size, 1'b0});
		n3   = n1 + n2;
		ge1  = (i4 >= n1);
		ge2  = (i4 >= n2);
		ge3  = (i4 >= n3);
		quad = ge3 ? 2'd3 : (ge2 ? 2'd2 : (ge1 ? 2'd1 : 2'd0));
		base = ge3 ? n3 : (ge2 ? n2 : (ge1 ? n1 : '0));
		rq   = i4 - base;
		m_nx = quad[0] ? SIZE_W'(n1 - rq) : rq[SIZE_W-1:0];
		tag_nx.quad = quad;
		tag_nx.zero = (m_nx == '0);
		tag_nx.full = (m_nx >= size);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1   <= m_nx;
			tag_s1 <= tag_nx;
			dvd_s2 <= DVD_W'(PI_Q30 * m_s1) + DVD_W'(size);
			tag_s2 <= tag_s1;
		end
	end

	// restoring divider, theta = round(pi*m / 2n)
	logic [DIV_REM_W-1:0] dsr;
	assign dsr = {size, 1'b0};

	logic [DIV_REM_W-1:0] div_rem_s  [DIV_STAGES];
	logic [DIV_QBITS-1:0] div_work_s [DIV_STAGES];
	cos_tag_t             div_tag_s  [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [DIV_REM_W-1:0] rem_in, rem_nx;
		logic [DIV_QBITS-1:0] work_in, work_nx;
		logic [DIV_REM_W:0]   trial;
		cos_tag_t             tag_in;

		if (k == 0) begin : g_first
			assign rem_in  = dvd_s2[DVD_W-1 -: DIV_REM_W];
			assign work_in = dvd_s2[DIV_QBITS-1:0];
			assign tag_in  = tag_s2;
		end else begin : g_next
			assign rem_in  = div_rem_s[k-1];
			assign work_in = div_work_s[k-1];
			assign tag_in  = div_tag_s[k-1];
		end

		always_comb begin
			rem_nx  = rem_in;
			work_nx = work_in;
			trial   = '0;
			for (int j = 0; j < DIV_PER_STAGE; j++) begin
				if (k * DIV_PER_STAGE + j < DIV_QBITS) begin
					trial = {rem_nx, work_nx[DIV_QBITS-1]};
					if (trial >= {1'b0, dsr}) begin
						rem_nx  = DIV_REM_W'(trial - {1'b0, dsr});
						work_nx = {work_nx[DIV_QBITS-2:0], 1'b1};
					end else begin
						rem_nx  = trial[DIV_REM_W-1:0];
						work_nx = {work_nx[DIV_QBITS-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_rem_s[k]  <= rem_nx;
				div_work_s[k] <= work_nx;
				div_tag_s[k]  <= tag_in;
			end
		end
	end

	// theta squared in q2.30
	logic [2*DIV_QBITS:0] sq_sum;
	logic [T2_W-1:0]      t2_s11;
	cos_tag_t             tag_s11;

	assign sq_sum = (2*DIV_QBITS+1)'(div_work_s[DIV_STAGES-1] * div_work_s[DIV_STAGES-1])
		+ (2*DIV_QBITS+1)'(64'd1 << 29);

	always_ff @(posedge clk) begin
		if (adv) begin
			t2_s11  <= T2_W'(sq_sum >> 30);
			tag_s11 <= div_tag_s[DIV_STAGES-1];
		end
	end

	// horner steps: multiply, reciprocal or shift, correct and subtract
	logic [Y_W-1:0]  ha_y_s  [HORNER_TERMS];
	logic [T2_W-1:0] ha_t2_s [HORNER_TERMS];
	cos_tag_t        ha_tag_s[HORNER_TERMS];
	logic [Y_W-1:0]  hb_y_s  [HORNER_TERMS];
	logic [Q0_W-1:0] hb_q0_s [HORNER_TERMS];
	logic [T2_W-1:0] hb_t2_s [HORNER_TERMS];
	cos_tag_t        hb_tag_s[HORNER_TERMS];
	logic [R_W-1:0]  hc_r_s  [HORNER_TERMS];
	logic [T2_W-1:0] hc_t2_s [HORNER_TERMS];
	cos_tag_t        hc_tag_s[HORNER_TERMS];

	for (genvar k = 0; k < HORNER_TERMS; k++) begin : g_horner
		localparam int                  DV   = HORNER_DIV[k];
		localparam logic [T2_W+R_W-1:0] HALF = (T2_W+R_W)'(DV) << 29;

		logic [T2_W-1:0]     t2_in;
		logic [R_W-1:0]      r_in;
		cos_tag_t            tag_in;
		logic [T2_W+R_W-1:0] xsum;
		logic [Q0_W-1:0]     q0_nx;
		logic [Y_W-1:0]      qd, rem;
		logic [Q0_W:0]       step;
		logic [R_W-1:0]      r_nx;

		if (k == 0) begin : g_first
			assign t2_in  = t2_s11;
			assign r_in   = Q30_ONE;
			assign tag_in = tag_s11;
		end else begin : g_next
			assign t2_in  = hc_t2_s[k-1];
			assign r_in   = hc_r_s[k-1];
			assign tag_in = hc_tag_s[k-1];
		end

		assign xsum = (T2_W+R_W)'(t2_in * r_in) + HALF;

		if ((DV & (DV - 1)) == 0) begin : g_shift
			assign q0_nx = Q0_W'(ha_y_s[k] >> $clog2(DV));
		end else begin : g_recip
			localparam logic [31:0] RECIP = 32'((64'd1 << 33) / DV);
			logic [Y_W+31:0] rmul;
			assign rmul  = (Y_W+32)'(ha_y_s[k] * RECIP);
			assign q0_nx = Q0_W'(rmul >> 33);
		end

		always_comb begin
			qd   = Y_W'(hb_q0_s[k] * Y_W'(DV));
			rem  = hb_y_s[k] - qd;
			step = (Q0_W+1)'(hb_q0_s[k]) + ((rem >= Y_W'(DV)) ? (Q0_W+1)'(1) : '0);
			r_nx = (step >= (Q0_W+1)'(Q30_ONE)) ? '0 : R_W'((Q0_W+1)'(Q30_ONE) - step);
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ha_y_s[k]   <= xsum[T2_W+R_W-1:30];
				ha_t2_s[k]  <= t2_in;
				ha_tag_s[k] <= tag_in;
				hb_y_s[k]   <= ha_y_s[k];
				hb_q0_s[k]  <= q0_nx;
				hb_t2_s[k]  <= ha_t2_s[k];
				hb_tag_s[k] <= ha_tag_s[k];
				hc_r_s[k]   <= r_nx;
				hc_t2_s[k]  <= hb_t2_s[k];
				hc_tag_s[k] <= hb_tag_s[k];
			end
		end
	end

	// signed cosine times (alpha - 1), then add alpha
	cos_tag_t                   tag_fin;
	logic [R_W-1:0]             cabs;
	logic signed [FACTOR_W-1:0] cs;
	logic signed [ALPHA_W:0]    am;
	logic signed [PRD_W-1:0]    prd_s30, rnd;
	logic signed [FACTOR_W-1:0] fac_s31;

	assign tag_fin = hc_tag_s[HORNER_TERMS-1];

	always_comb begin
		cabs = tag_fin.zero ? Q30_ONE : (tag_fin.full ? '0 : hc_r_s[HORNER_TERMS-1]);
		cs   = (tag_fin.quad == 2'd1 || tag_fin.quad == 2'd2) ?
			-$signed({1'b0, cabs}) : $signed({1'b0, cabs});
		am   = $signed({1'b0, alpha}) - $signed({1'b0, ALPHA_ONE});
		rnd  = prd_s30 + $signed(PRD_W'(1 << 14));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prd_s30 <= am * cs;
			fac_s31 <= FACTOR_W'(rnd >>> 15) + $signed({1'b0, alpha, 15'b0});
		end
	end

	assign factor = fac_s31;

endmodule

@@ rtl/core/raised_cosine_window_2d_top.sv @@
// ----------------------------------------------------------------------------
// raised_cosine_window_2d_top
// one coefficient of a separable 2-d generalised hamming window per transfer
// ----------------------------------------------------------------------------
// channel   dir  tdata                          tuser
// s_axis    in   column_index[9:0] row_index[19:10]   -
// m_axis    out  coefficient[COEF_BITS-1:0]     out_of_range
// cfg       in   write port, index 0 width, 1 height, 2 alpha
//
// one transfer accepted per cycle while the skid stage is empty; its result
// passes through 33 register stages, among them the 8-stage angle divider
// and the 18-stage horner series
// reset sets width 1, height 1, alpha 16384 and empties the pipeline
// the whole pipeline stalls only while the output skid stage is occupied,
// so s_axis_tready follows the skid register alone
// ----------------------------------------------------------------------------
module raised_cosine_window_2d_top #(
	parameter int MAX_SIZE  = 1024,
	parameter int COEF_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// column_index, row_index
	input  logic [rcw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// coefficient
	output logic [((COEF_BITS+7)/8)*8-1:0]      m_axis_tdata,
	// out_of_range
	output logic                                m_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic                                cfg_we,
	input  logic [rcw_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [rcw_pkg::CFG_W-1:0]           cfg_wdata
);
	import rcw_pkg::*;

	localparam int OUT_W    = ((COEF_BITS + 7) / 8) * 8;
	localparam int PIPE_LAT = AXIS_LAT + 1;
	localparam int RND_SH   = 60 - (COEF_BITS - 1);
	localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (RND_SH - 1);
	localparam logic signed [63:0] COEF_MAX = (64'sd1 <<< (COEF_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] COEF_MIN = -(64'sd1 <<< (COEF_BITS - 1));

	// configuration, held already clamped
	logic [SIZE_W-1:0]  width_q, height_q, size_wr;
	logic [ALPHA_W-1:0] alpha_q, alpha_wr;

	always_comb begin
		size_wr = cfg_wdata[SIZE_W-1:0];
		if (size_wr == '0) begin
			size_wr = SIZE_W'(1);
		end else if (32'(size_wr) > 32'(MAX_SIZE)) begin
			size_wr = SIZE_W'(MAX_SIZE);
		end
		alpha_wr = (cfg_wdata > ALPHA_ONE) ? ALPHA_ONE : cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(1);
			height_q <= SIZE_W'(1);
			alpha_q  <= ALPHA_W'(16384);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_WIDTH_SIZE: begin
					width_q <= size_wr;
				end
				REG_HEIGHT_SIZE: begin
					height_q <= size_wr;
				end
				REG_ALPHA: begin
					alpha_q <= alpha_wr;
				end
				default: begin
				end
			endcase
		end
	end

	// pipeline control
	logic                adv;
	logic                skid_valid_q;
	logic [PIPE_LAT-1:0] vld_s;
	logic [PIPE_LAT-1:0] oor_s;
	logic [IDX_W-1:0]    col_in, row_in;
	logic                oor_in;

	assign adv           = !skid_valid_q;
	assign s_axis_tready = !skid_valid_q;
	assign col_in        = s_axis_tdata[IDX_W-1:0];
	assign row_in        = s_axis_tdata[2*IDX_W-1:IDX_W];
	assign oor_in        = ({1'b0, col_in} >= width_q) || ({1'b0, row_in} >= height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[PIPE_LAT-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s <= {oor_s[PIPE_LAT-2:0], oor_in};
		end
	end

	// axis factors
	logic signed [FACTOR_W-1:0] fx, fy, fy_sel;

	rcw_axis u_col (
		.clk    (clk),
		.adv    (adv),
		.index  (col_in),
		.size   (width_q),
		.alpha  (alpha_q),
		.factor (fx)
	);

	rcw_axis u_row (
		.clk    (clk),
		.adv    (adv),
		.index  (row_in),
		.size   (height_q),
		.alpha  (alpha_q),
		.factor (fy)
	);

	// product, rounding, saturation and zeroing of out-of-range results
	logic signed [63:0]     prd_s32, rnd_p, res_p;
	logic [COEF_BITS-1:0]   coef_nx;

	assign fy_sel = (height_q == SIZE_W'(1)) ?
		$signed(FACTOR_W'(Q30_ONE)) : fy;

	always_ff @(posedge clk) begin
		if (adv) begin
			prd_s32 <= fx * fy_sel;
		end
	end

	always_comb begin
		rnd_p = prd_s32 + RND_HALF;
		res_p = rnd_p >>> RND_SH;
		if (oor_s[PIPE_LAT-1]) begin
			coef_nx = '0;
		end else if (res_p > COEF_MAX) begin
			coef_nx = COEF_BITS'(COEF_MAX);
		end else if (res_p < COEF_MIN) begin
			coef_nx = COEF_BITS'(COEF_MIN);
		end else begin
			coef_nx = COEF_BITS'(res_p);
		end
	end

	// output register and skid stage
	logic                 out_valid_q, out_oor_q, skid_oor_q;
	logic [COEF_BITS-1:0] out_coef_q, skid_coef_q;
	logic                 res_v;

	assign res_v = vld_s[PIPE_LAT-1] && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_axis_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_v) begin
			if (!out_valid_q || m_axis_tready) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_axis_tready) begin
				out_coef_q <= skid_coef_q;
				out_oor_q  <= skid_oor_q;
			end
		end else if (res_v) begin
			if (!out_valid_q || m_axis_tready) begin
				out_coef_q <= coef_nx;
				out_oor_q  <= oor_s[PIPE_LAT-1];
			end else begin
				skid_coef_q <= coef_nx;
				skid_oor_q  <= oor_s[PIPE_LAT-1];
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_coef_q);
	assign m_axis_tuser  = out_oor_q;

endmodule
